// ===== sv/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Sizes of the used map, request and status codes, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Capacity of the used map in pages
    localparam int MAX_PAGES  = 65536;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int WORD_W     = 32;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = MAX_PAGES / WORD_W;
    localparam int WADDR_W    = $clog2(NUM_WORDS);

    // Port widths
    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 40;
    localparam int M_USER_W   = 2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TOTAL    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_RESERVED = 1'b1;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_BAD_FREE = 2'd2
    } pfa_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_RESULT
    } pfa_state_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic lookup;
        logic eval;
        logic load_out;
    } pfa_cmd_t;

    typedef struct packed {
        logic cfg_hit;
        logic clr_last;
        logic lookup_done;
        logic eval_done;
        logic out_room;
    } pfa_sts_t;

endpackage

// ===== sv/pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfa_ctrl: sequencer of the page frame allocator
// Walks the clearing pass, request intake, lookup, map scan and result
// hand-off; the datapath reports when each phase is finished.
// ----------------------------------------------------------------------------
module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  pfa_sts_t sts,
    output pfa_cmd_t cmd
);

    pfa_state_t state_reg;
    pfa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                state_next = sts.lookup_done ? ST_RESULT : ST_EVAL;
            end
            ST_EVAL: begin
                if (sts.eval_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_room) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        // a register write restarts the clearing pass
        if (sts.cfg_hit) state_next = ST_CLEAR;
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                s_tready   = !sts.cfg_hit;
                cmd.accept = s_tvalid && !sts.cfg_hit;
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_RESULT: begin
                cmd.load_out = sts.out_room;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/pfa_dpath.sv =====
// ----------------------------------------------------------------------------
// pfa_dpath: used map, hint, counters and result register
// Holds the used map as 32-bit words, scans one word per cycle for the
// lowest free page and updates the map with a read-modify-write.
// ----------------------------------------------------------------------------
module pfa_dpath
    import pfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [M_USER_W-1:0]   m_tuser,
    input  pfa_cmd_t              cmd,
    output pfa_sts_t              sts
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);

    // used map
    logic [WORD_W-1:0]  used_map_mem [NUM_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [WADDR_W-1:0] rd_addr;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    // control and payload registers
    logic [CNT_W-1:0]   total_reg,   total_next;
    logic [CNT_W-1:0]   resv_reg,    resv_next;
    logic [CNT_W-1:0]   hint_reg,    hint_next;
    logic [CNT_W-1:0]   used_reg,    used_next;
    logic [WADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               req_free_reg;
    logic [PAGE_W-1:0]  req_page_reg;
    logic [PAGE_W-1:0]  cur_reg,     cur_next;
    pfa_status_t        res_sts_reg, res_sts_next;
    logic [PAGE_W-1:0]  res_page_reg, res_page_next;
    pfa_status_t        out_sts_reg;
    logic [PAGE_W-1:0]  out_page_reg;
    logic [CNT_W-1:0]   out_free_reg;

    // derived values
    logic [CNT_W-1:0]   eff_tot;
    logic [CNT_W-1:0]   eff_res;
    logic [CNT_W-1:0]   start;
    logic [CNT_W-1:0]   req_page_ext;
    logic               free_bad;
    logic [WADDR_W-1:0] cur_word;
    logic [OFF_W-1:0]   cur_off;
    logic [WORD_W-1:0]  masked;
    logic               found;
    logic [OFF_W-1:0]   zero_idx;
    logic [CNT_W-1:0]   hit_page;
    logic               hit;
    logic [WADDR_W:0]   next_word_ext;
    logic [CNT_W-1:0]   next_base;
    logic               more;
    logic [OFF_W-1:0]   free_off;
    logic               free_bit;
    logic [CNT_W-1:0]   avail;
    logic [CNT_W-1:0]   free_now;

    assign eff_tot      = (total_reg > MAX_CNT) ? MAX_CNT : total_reg;
    assign eff_res      = (resv_reg < eff_tot) ? resv_reg : eff_tot;
    assign start        = (hint_reg > eff_res) ? hint_reg : eff_res;
    assign req_page_ext = {1'b0, req_page_reg};
    assign free_bad     = (req_page_ext < eff_res) || (req_page_ext >= eff_tot);

    // lowest free page in the current word, pages below the scan start count as used
    assign cur_word = cur_reg[PAGE_W-1:OFF_W];
    assign cur_off  = cur_reg[OFF_W-1:0];
    assign masked   = rd_data_reg | ((WORD_W'(1) << cur_off) - WORD_W'(1));

    always_comb begin
        found    = 1'b0;
        zero_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                found    = 1'b1;
                zero_idx = OFF_W'(i);
            end
        end
    end

    assign hit_page      = {1'b0, cur_word, zero_idx};
    assign hit           = found && (hit_page < eff_tot);
    assign next_word_ext = {1'b0, cur_word} + (WADDR_W + 1)'(1);
    assign next_base     = {next_word_ext, OFF_W'(0)};
    assign more          = !found && (next_base < eff_tot);

    assign free_off = req_page_reg[OFF_W-1:0];
    assign free_bit = rd_data_reg[free_off];

    assign avail    = eff_tot - eff_res;
    assign free_now = (used_reg < avail) ? (avail - used_reg) : '0;

    // map port selection
    always_comb begin
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd.lookup) begin
            rd_addr = req_free_reg ? req_page_reg[PAGE_W-1:OFF_W] : start[PAGE_W-1:OFF_W];
        end
        if (cmd.eval) begin
            rd_addr = next_word_ext[WADDR_W-1:0];
        end
        if (cmd.clr_step) begin
            mem_we = 1'b1;
        end
        if (cmd.eval && !req_free_reg && hit) begin
            mem_we    = 1'b1;
            mem_waddr = cur_word;
            mem_wdata = rd_data_reg | (WORD_W'(1) << zero_idx);
        end
        if (cmd.eval && req_free_reg && free_bit) begin
            mem_we    = 1'b1;
            mem_waddr = req_page_reg[PAGE_W-1:OFF_W];
            mem_wdata = rd_data_reg & ~(WORD_W'(1) << free_off);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            used_map_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= used_map_mem[rd_addr];
    end

    // next values
    always_comb begin
        total_next    = total_reg;
        resv_next     = resv_reg;
        hint_next     = hint_reg;
        used_next     = used_reg;
        clr_cnt_next  = clr_cnt_reg;
        cur_next      = cur_reg;
        res_sts_next  = res_sts_reg;
        res_page_next = res_page_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cmd.clr_step) begin
            clr_cnt_next = clr_cnt_reg + WADDR_W'(1);
        end

        if (cmd.lookup) begin
            cur_next      = start[PAGE_W-1:0];
            res_page_next = '0;
            res_sts_next  = STS_OK;
            if (req_free_reg && free_bad) begin
                res_sts_next = STS_BAD_FREE;
            end else if (!req_free_reg && (start >= eff_tot)) begin
                res_sts_next = STS_NO_FREE;
            end
        end

        if (cmd.eval) begin
            if (req_free_reg) begin
                if (free_bit) begin
                    res_sts_next = STS_OK;
                    if (used_reg != '0) used_next = used_reg - CNT_W'(1);
                    if (req_page_ext < hint_reg) hint_next = req_page_ext;
                end else begin
                    res_sts_next = STS_BAD_FREE;
                end
            end else if (hit) begin
                res_sts_next  = STS_OK;
                res_page_next = hit_page[PAGE_W-1:0];
                used_next     = used_reg + CNT_W'(1);
                hint_next     = hit_page + CNT_W'(1);
            end else if (more) begin
                cur_next = next_base[PAGE_W-1:0];
            end else begin
                res_sts_next = STS_NO_FREE;
            end
        end

        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // any register write starts the allocator over
        if (cfg_we) begin
            if (cfg_addr == REG_TOTAL) total_next = cfg_wdata;
            if (cfg_addr == REG_RESERVED) resv_next = cfg_wdata;
            hint_next    = '0;
            used_next    = '0;
            clr_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= MAX_CNT;
            resv_reg     <= '0;
            hint_reg     <= '0;
            used_reg     <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            total_reg    <= total_next;
            resv_reg     <= resv_next;
            hint_reg     <= hint_next;
            used_reg     <= used_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_free_reg <= (s_tuser == REQ_FREE);
            req_page_reg <= s_tdata[PAGE_W-1:0];
        end
        cur_reg      <= cur_next;
        res_sts_reg  <= res_sts_next;
        res_page_reg <= res_page_next;
        if (cmd.load_out) begin
            out_sts_reg  <= res_sts_reg;
            out_page_reg <= res_page_reg;
            out_free_reg <= free_now;
        end
    end

    assign sts.cfg_hit     = cfg_we && ((cfg_addr == REG_TOTAL) || (cfg_addr == REG_RESERVED));
    assign sts.clr_last    = (clr_cnt_reg == WADDR_W'(NUM_WORDS - 1));
    assign sts.lookup_done = req_free_reg ? free_bad : (start >= eff_tot);
    assign sts.eval_done   = req_free_reg || !more;
    assign sts.out_room    = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_sts_reg;
    assign m_tdata  = {(M_DATA_W - CNT_W - PAGE_W)'(0), out_free_reg, out_page_reg};

`ifndef SYNTHESIS
    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= avail)
        else $error("used count exceeds allocatable pages");

    a_grant_above_reserved: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval && !req_free_reg && hit) |-> (hit_page >= eff_res))
        else $error("granted page lies in the reserved range");

    a_clear_idle_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> (used_reg == '0) && (hint_reg == '0))
        else $error("counters not cleared during clearing pass");

    a_load_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken word");

    a_no_scan_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_step |-> !cmd.eval && !cmd.lookup && !cmd.accept)
        else $error("request handled during clearing pass");
`endif

endmodule

// ===== sv/page_frame_allocator_top.sv =====
// Sequence: an allocate runs lookup, an eval scan of used-map words, then result and m_tvalid.
// Free: lookup, eval, result. Frees outside the pool and allocates at or past the total skip eval.
// Throughput: one word at a time; the next word is taken as soon as its result is registered.
// The scan reads one 32-page word of the used map per cycle from its single read port.
// After aresetn (synchronous, active low) and after every register write, a clearing pass
// zeroes the used map word by word; s_tready stays low until it is done.
// ----------------------------------------------------------------------------
// page_frame_allocator_top: bitmap page frame allocator
// Keeps one used bit per physical page, grants the lowest free page at or
// above a next-fit hint, frees pages back and reports the free-page count.
// ----------------------------------------------------------------------------
module page_frame_allocator_top
    import pfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: index 0 total_pages, index 1 reserved_pages
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // request words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] page_number
    input  logic                  s_tuser,   // [0] req_type
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [15:0] granted_page, [32:16] free_count, rest zero
    output logic [M_USER_W-1:0]   m_tuser    // [1:0] status
);

    pfa_cmd_t cmd;
    pfa_sts_t sts;

    // Sequencer: clear pass, intake, lookup, word scan, result hand-off
    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Used map, hint, counters and the output register; the output register
    // lets a new request enter while the previous result still waits
    pfa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
